// ===== rtl/ezpm_pkg.sv =====
// Shared constants and arithmetic helpers for the Euler-to-pose-matrix pipeline.
// Used by ezpm_cordic, ezpm_matrix and euler_zyx_to_pose_matrix.
package ezpm_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int MATRIX_FRAC_BITS = 14;
    localparam int CORDIC_STEPS     = 16;

    localparam int CORDIC_W  = 34;
    localparam int SC_W      = 32;
    localparam int SUM_W     = SC_W + 1;
    localparam int ENTRY_W   = 16;
    localparam int TRANS_W   = 32;
    localparam int MAT_LAT   = 3;
    localparam int PIPE_LAT  = CORDIC_STEPS + 2 + MAT_LAT;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(32'h26DD3B6A);

    localparam int ENT_SH = 30 - MATRIX_FRAC_BITS;
    localparam logic signed [SUM_W:0] ENT_RND =
        (ENT_SH > 0) ? (SUM_W+1)'(64'd1 << (ENT_SH - 1)) : '0;
    localparam logic signed [SUM_W:0] ENT_LIM = (SUM_W+1)'(64'd1 << MATRIX_FRAC_BITS);

    function automatic logic [31:0] atan_at(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [SC_W-1:0] q30_mul(input logic signed [SC_W-1:0] a,
                                                       input logic signed [SC_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return SC_W'(p >>> 30);
    endfunction

    function automatic logic signed [ENTRY_W-1:0] to_entry(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] t;
        t = ((SUM_W+1)'(v) + ENT_RND) >>> ENT_SH;
        if (t > ENT_LIM) begin
            t = ENT_LIM;
        end else if (t < -ENT_LIM) begin
            t = -ENT_LIM;
        end
        return ENTRY_W'(t);
    endfunction

endpackage

// ===== rtl/euler_zyx_to_pose_matrix.sv =====
// Top level: ZYX Euler angles plus translation to the top three rows of a pose matrix.
// Depends on ezpm_pkg, ezpm_cordic and ezpm_matrix.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | i_valid / o_stall  | i_roll/pitch/yaw_angle, i_trans_x/y/z
//  out     | o_valid / i_stall  | o_r00..o_r22, o_out_x/y/z
//
// One pose per cycle while the output is not held; the pipeline is the
// CORDIC stage chain plus three product/rounding stages.
// Reset clears the valid bits only. A held result freezes the whole pipeline;
// transfers resume with nothing lost or repeated.
module euler_zyx_to_pose_matrix import ezpm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [15:0]        i_roll_angle,
    input  logic signed [15:0]        i_pitch_angle,
    input  logic signed [15:0]        i_yaw_angle,
    input  logic signed [TRANS_W-1:0] i_trans_x,
    input  logic signed [TRANS_W-1:0] i_trans_y,
    input  logic signed [TRANS_W-1:0] i_trans_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [ENTRY_W-1:0] o_r00,
    output logic signed [ENTRY_W-1:0] o_r01,
    output logic signed [ENTRY_W-1:0] o_r02,
    output logic signed [ENTRY_W-1:0] o_r10,
    output logic signed [ENTRY_W-1:0] o_r11,
    output logic signed [ENTRY_W-1:0] o_r12,
    output logic signed [ENTRY_W-1:0] o_r20,
    output logic signed [ENTRY_W-1:0] o_r21,
    output logic signed [ENTRY_W-1:0] o_r22,
    output logic signed [TRANS_W-1:0] o_out_x,
    output logic signed [TRANS_W-1:0] o_out_y,
    output logic signed [TRANS_W-1:0] o_out_z
);

    logic                      en;
    logic [PIPE_LAT-1:0]       r_valid;
    logic signed [TRANS_W-1:0] r_tx [0:PIPE_LAT-1];
    logic signed [TRANS_W-1:0] r_ty [0:PIPE_LAT-1];
    logic signed [TRANS_W-1:0] r_tz [0:PIPE_LAT-1];
    logic signed [SC_W-1:0]    sr, cr, sp, cp, sy, cy;

    assign en      = ~r_valid[PIPE_LAT-1] | ~i_stall;
    assign o_stall = r_valid[PIPE_LAT-1] & i_stall;
    assign o_valid = r_valid[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[PIPE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= i_trans_x;
            r_ty[0] <= i_trans_y;
            r_tz[0] <= i_trans_z;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_tx[i] <= r_tx[i-1];
                r_ty[i] <= r_ty[i-1];
                r_tz[i] <= r_tz[i-1];
            end
        end
    end

    ezpm_cordic u_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(i_roll_angle[ANGLE_BITS-1:0]),
        .o_sin(sr), .o_cos(cr)
    );

    ezpm_cordic u_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pitch_angle[ANGLE_BITS-1:0]),
        .o_sin(sp), .o_cos(cp)
    );

    ezpm_cordic u_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(i_yaw_angle[ANGLE_BITS-1:0]),
        .o_sin(sy), .o_cos(cy)
    );

    ezpm_matrix u_matrix (
        .i_clk(i_clk), .i_en(en),
        .i_sr(sr), .i_cr(cr), .i_sp(sp), .i_cp(cp), .i_sy(sy), .i_cy(cy),
        .o_r00(o_r00), .o_r01(o_r01), .o_r02(o_r02),
        .o_r10(o_r10), .o_r11(o_r11), .o_r12(o_r12),
        .o_r20(o_r20), .o_r21(o_r21), .o_r22(o_r22)
    );

    assign o_out_x = r_tx[PIPE_LAT-1];
    assign o_out_y = r_ty[PIPE_LAT-1];
    assign o_out_z = r_tz[PIPE_LAT-1];

endmodule

// ===== rtl/ezpm_cordic.sv =====
// Pipelined rotation-mode CORDIC lane: quadrant fold, one stage per step, sign fix.
// Depends on ezpm_pkg.
module ezpm_cordic import ezpm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output logic signed [SC_W-1:0]       o_sin,
    output logic signed [SC_W-1:0]       o_cos
);

    logic signed [CORDIC_W-1:0] r_x [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_y [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_z [0:CORDIC_STEPS];
    logic                       r_neg [0:CORDIC_STEPS];
    logic signed [SC_W-1:0]     r_sin;
    logic signed [SC_W-1:0]     r_cos;
    logic [31:0]                n_a;
    logic                       n_neg;

    always_comb begin
        n_a   = 32'(i_angle) << (32 - ANGLE_BITS);
        n_neg = n_a[31] ^ n_a[30];
        n_a[31] = n_a[31] ^ n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= CORDIC_W'(signed'(n_a));
            r_neg[0] <= n_neg;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - signed'(CORDIC_W'(atan_at(i)));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + signed'(CORDIC_W'(atan_at(i)));
                end
            end
            r_sin <= r_neg[CORDIC_STEPS] ? SC_W'(-r_y[CORDIC_STEPS]) : SC_W'(r_y[CORDIC_STEPS]);
            r_cos <= r_neg[CORDIC_STEPS] ? SC_W'(-r_x[CORDIC_STEPS]) : SC_W'(r_x[CORDIC_STEPS]);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== rtl/ezpm_matrix.sv =====
// Three-stage product tree forming the ZYX rotation matrix from sines and cosines.
// Depends on ezpm_pkg.
module ezpm_matrix import ezpm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [SC_W-1:0]    i_sr,
    input  logic signed [SC_W-1:0]    i_cr,
    input  logic signed [SC_W-1:0]    i_sp,
    input  logic signed [SC_W-1:0]    i_cp,
    input  logic signed [SC_W-1:0]    i_sy,
    input  logic signed [SC_W-1:0]    i_cy,
    output logic signed [ENTRY_W-1:0] o_r00,
    output logic signed [ENTRY_W-1:0] o_r01,
    output logic signed [ENTRY_W-1:0] o_r02,
    output logic signed [ENTRY_W-1:0] o_r10,
    output logic signed [ENTRY_W-1:0] o_r11,
    output logic signed [ENTRY_W-1:0] o_r12,
    output logic signed [ENTRY_W-1:0] o_r20,
    output logic signed [ENTRY_W-1:0] o_r21,
    output logic signed [ENTRY_W-1:0] o_r22
);

    logic signed [SC_W-1:0] r_a_cysp, r_a_sysp, r_a_cycp, r_a_sycp, r_a_cpsr, r_a_cpcr;
    logic signed [SC_W-1:0] r_a_sycr, r_a_sysr, r_a_cycr, r_a_cysr;
    logic signed [SC_W-1:0] r_a_sr, r_a_cr, r_a_sp;
    logic signed [SC_W-1:0] r_b_p01, r_b_p02, r_b_p11, r_b_p12;
    logic signed [SC_W-1:0] r_b_cycp, r_b_sycp, r_b_cpsr, r_b_cpcr;
    logic signed [SC_W-1:0] r_b_sycr, r_b_sysr, r_b_cycr, r_b_cysr, r_b_sp;
    logic signed [ENTRY_W-1:0] r_r00, r_r01, r_r02, r_r10, r_r11, r_r12, r_r20, r_r21, r_r22;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cysp <= q30_mul(i_cy, i_sp);
            r_a_sysp <= q30_mul(i_sy, i_sp);
            r_a_cycp <= q30_mul(i_cy, i_cp);
            r_a_sycp <= q30_mul(i_sy, i_cp);
            r_a_cpsr <= q30_mul(i_cp, i_sr);
            r_a_cpcr <= q30_mul(i_cp, i_cr);
            r_a_sycr <= q30_mul(i_sy, i_cr);
            r_a_sysr <= q30_mul(i_sy, i_sr);
            r_a_cycr <= q30_mul(i_cy, i_cr);
            r_a_cysr <= q30_mul(i_cy, i_sr);
            r_a_sr   <= i_sr;
            r_a_cr   <= i_cr;
            r_a_sp   <= i_sp;

            r_b_p01  <= q30_mul(r_a_cysp, r_a_sr);
            r_b_p02  <= q30_mul(r_a_cysp, r_a_cr);
            r_b_p11  <= q30_mul(r_a_sysp, r_a_sr);
            r_b_p12  <= q30_mul(r_a_sysp, r_a_cr);
            r_b_cycp <= r_a_cycp;
            r_b_sycp <= r_a_sycp;
            r_b_cpsr <= r_a_cpsr;
            r_b_cpcr <= r_a_cpcr;
            r_b_sycr <= r_a_sycr;
            r_b_sysr <= r_a_sysr;
            r_b_cycr <= r_a_cycr;
            r_b_cysr <= r_a_cysr;
            r_b_sp   <= r_a_sp;

            r_r00 <= to_entry(SUM_W'(r_b_cycp));
            r_r01 <= to_entry(SUM_W'(r_b_p01) - SUM_W'(r_b_sycr));
            r_r02 <= to_entry(SUM_W'(r_b_p02) + SUM_W'(r_b_sysr));
            r_r10 <= to_entry(SUM_W'(r_b_sycp));
            r_r11 <= to_entry(SUM_W'(r_b_p11) + SUM_W'(r_b_cycr));
            r_r12 <= to_entry(SUM_W'(r_b_p12) - SUM_W'(r_b_cysr));
            r_r20 <= to_entry(-SUM_W'(r_b_sp));
            r_r21 <= to_entry(SUM_W'(r_b_cpsr));
            r_r22 <= to_entry(SUM_W'(r_b_cpcr));
        end
    end

    assign o_r00 = r_r00;
    assign o_r01 = r_r01;
    assign o_r02 = r_r02;
    assign o_r10 = r_r10;
    assign o_r11 = r_r11;
    assign o_r12 = r_r12;
    assign o_r20 = r_r20;
    assign o_r21 = r_r21;
    assign o_r22 = r_r22;

endmodule

// ===== tb/sv/tb_euler_zyx_to_pose_matrix.sv =====
// Testbench for euler_zyx_to_pose_matrix: drives poses, predicts the pose matrix
// with an independent CORDIC and fixed-point model, and checks every result in order.
// Depends on ezpm_pkg and the RTL of euler_zyx_to_pose_matrix.
`timescale 1ns / 100ps

module tb_euler_zyx_to_pose_matrix;
    import ezpm_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic signed [31:0] ox, oy, oz;
    } t_pose_matrix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_roll_angle = '0, i_pitch_angle = '0, i_yaw_angle = '0;
    logic signed [31:0] i_trans_x = '0, i_trans_y = '0, i_trans_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;

    t_pose_matrix matrix_q[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    euler_zyx_to_pose_matrix uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return floor_shift(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic logic [31:0] arctan_step(int i);
        logic [31:0] t [0:31] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return (i < 32) ? t[i] : 32'h0;
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
        logic [31:0] a;
        logic flip;
        longint x, y, z, dx, dy, t;
        a = {ang, 16'h0};
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip) a[31] = ~a[31];
        x = 64'sh26DD3B6A;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t = longint'(arctan_step(i));
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic logic signed [15:0] round_entry(longint v);
        int sh;
        longint lim;
        sh = 30 - MATRIX_FRAC_BITS;
        lim = 64'sd1 << MATRIX_FRAC_BITS;
        if (sh > 0) v = floor_shift(v + (64'sd1 << (sh - 1)), sh);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    task automatic predict_matrix(input t_pose p, output t_pose_matrix m);
        longint sr, cr, sp, cp, sy, cy, cysp, sysp;
        sin_cos(p.roll, sr, cr);
        sin_cos(p.pitch, sp, cp);
        sin_cos(p.yaw, sy, cy);
        cysp = mul_q30(cy, sp);
        sysp = mul_q30(sy, sp);
        m.m00 = round_entry(mul_q30(cy, cp));
        m.m01 = round_entry(mul_q30(cysp, sr) - mul_q30(sy, cr));
        m.m02 = round_entry(mul_q30(cysp, cr) + mul_q30(sy, sr));
        m.m10 = round_entry(mul_q30(sy, cp));
        m.m11 = round_entry(mul_q30(sysp, sr) + mul_q30(cy, cr));
        m.m12 = round_entry(mul_q30(sysp, cr) - mul_q30(cy, sr));
        m.m20 = round_entry(-sp);
        m.m21 = round_entry(mul_q30(cp, sr));
        m.m22 = round_entry(mul_q30(cp, cr));
        m.ox = p.tx;
        m.oy = p.ty;
        m.oz = p.tz;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_pose(input t_pose p);
        t_pose_matrix m;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_matrix(p, m);
        i_valid <= 1'b1;
        i_roll_angle <= p.roll;
        i_pitch_angle <= p.pitch;
        i_yaw_angle <= p.yaw;
        i_trans_x <= p.tx;
        i_trans_y <= p.ty;
        i_trans_z <= p.tz;
        do @(posedge i_clk); while (o_stall);
        matrix_q.push_back(m);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_pose rand_pose();
        t_pose p;
        p.roll = 16'($urandom);
        p.pitch = 16'($urandom);
        p.yaw = 16'($urandom);
        p.tx = $urandom;
        p.ty = $urandom;
        p.tz = $urandom;
        return p;
    endfunction

    // receiver stall generation
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pose_matrix w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (matrix_q.size() == 0) begin
                report_mismatch("unexpected transfer", 0, 0);
            end else begin
                w = matrix_q.pop_front();
                if (o_r00 !== w.m00) report_mismatch("r00", o_r00, w.m00);
                if (o_r01 !== w.m01) report_mismatch("r01", o_r01, w.m01);
                if (o_r02 !== w.m02) report_mismatch("r02", o_r02, w.m02);
                if (o_r10 !== w.m10) report_mismatch("r10", o_r10, w.m10);
                if (o_r11 !== w.m11) report_mismatch("r11", o_r11, w.m11);
                if (o_r12 !== w.m12) report_mismatch("r12", o_r12, w.m12);
                if (o_r20 !== w.m20) report_mismatch("r20", o_r20, w.m20);
                if (o_r21 !== w.m21) report_mismatch("r21", o_r21, w.m21);
                if (o_r22 !== w.m22) report_mismatch("r22", o_r22, w.m22);
                if (o_out_x !== w.ox) report_mismatch("out_x", o_out_x, w.ox);
                if (o_out_y !== w.oy) report_mismatch("out_y", o_out_y, w.oy);
                if (o_out_z !== w.oz) report_mismatch("out_z", o_out_z, w.oz);
            end
        end
    end

    task automatic test_directed();
        logic signed [15:0] angs [0:11] = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7FFF,
            -16'sh8000, 16'sh2000, 16'sh3FFF, 16'sh4001, 16'shC000, 16'shBFFF, 16'sh0001,
            -16'sh0001};
        t_pose p;
        for (int i = 0; i < 12; i++) begin
            p.roll = angs[i];
            p.pitch = angs[(i + 5) % 12];
            p.yaw = angs[(i + 9) % 12];
            p.tx = (i % 2) ? 32'sh7FFFFFFF : -32'sh80000000;
            p.ty = (i % 3) ? 32'sh0 : 32'shFFFFFFFF;
            p.tz = $urandom;
            send_pose(p);
        end
        for (int i = 0; i < 12; i++) begin
            p = '0;
            p.pitch = angs[i];
            send_pose(p);
        end
        end_burst();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_pose(rand_pose());
        end_burst();
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 60; i++) send_pose(rand_pose());
        end_burst();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 36;
        recv_idle_pct = 75;
        test_random(420);
        send_idle_pct = 75;
        recv_idle_pct = 36;
        test_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        test_backpressure();
        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ezpm_pkg.sv
rtl/ezpm_cordic.sv
rtl/ezpm_matrix.sv
rtl/euler_zyx_to_pose_matrix.sv
tb/sv/tb_euler_zyx_to_pose_matrix.sv
